FILE: rtl/latest_frame_slot_pool_macros.svh
// Assertion macros for the slot pool.
`ifndef LATEST_FRAME_SLOT_POOL_MACROS_SVH
`define LATEST_FRAME_SLOT_POOL_MACROS_SVH
`ifndef SYNTH
`define LFSP_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define LFSP_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define LFSP_ASSERT_IMP(label, clk, rst_n, a, c)
`define LFSP_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/lfsp_pkg.sv
package lfsp_pkg;

	localparam logic [2:0] ACT_BEGIN   = 3'd0;
	localparam logic [2:0] ACT_FINISH  = 3'd1;
	localparam logic [2:0] ACT_ACQUIRE = 3'd2;
	localparam logic [2:0] ACT_RELEASE = 3'd3;
	localparam logic [2:0] ACT_GET     = 3'd4;

	localparam logic [2:0] PH_FREE    = 3'd0;
	localparam logic [2:0] PH_WRITING = 3'd1;
	localparam logic [2:0] PH_READY   = 3'd2;
	localparam logic [2:0] PH_RUNNING = 3'd3;
	localparam logic [2:0] PH_ERROR   = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	localparam logic [1:0] REG_ARENA0 = 2'd0;
	localparam logic [1:0] REG_ARENA1 = 2'd1;
	localparam logic [1:0] REG_STRIDE = 2'd2;
	localparam logic [1:0] REG_EXPECT = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [4:0]  stream;
		logic [63:0] frame_number;
		logic [63:0] capture_time;
		logic [31:0] format_version;
		logic [5:0]  handle_index;
		logic [31:0] handle_generation;
		logic [31:0] written_bytes;
		logic [31:0] write_fault;
		logic [2:0]  worker;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot_index;
		logic [31:0] slot_generation;
		logic [2:0]  slot_state;
		logic [31:0] buf_addr;
		logic [3:0]  holder;
		logic [63:0] slot_frame;
		logic [63:0] slot_timestamp;
		logic [31:0] slot_version;
		logic [31:0] slot_byte_count;
		logic [31:0] slot_error;
		logic [3:0]  slot_stream;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DECIDE,
		S_OLD,
		S_WRITE
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic capture;
		logic decide;
		logic check_old;
		logic commit;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic need_old;
	} sts_t;

endpackage

FILE: rtl/latest_frame_slot_pool.sv
// From start the controller steps through read, decide, an optional compare
// against the stream's previous ready frame for finish_write, and write.
// Busy stays high through write; done then comes from the output registers.
// Reset: asynchronous, all slots free, generation zero, no latest slot.
// The result is shown for one cycle with done; the receiver cannot stall.
`include "latest_frame_slot_pool_macros.svh"
module latest_frame_slot_pool #(
	parameter int CHANNELS = 16,
	parameter int SLOTS = 32,
	parameter int WORKERS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  lfsp_pkg::req_t req,
	output logic done,
	output lfsp_pkg::rsp_t rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import lfsp_pkg::*;

	logic [31:0] arena0_q, arena1_q, stride_q, expect_q;
	logic [1:0] ridx;
	logic done_i;
	rsp_t rsp_i;
	cmd_t cmd;
	sts_t sts;
	assign ridx = paddr[3:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena0_q <= '0; arena1_q <= '0; stride_q <= '0; expect_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_ARENA0: arena0_q <= pwdata;
				REG_ARENA1: arena1_q <= pwdata;
				REG_STRIDE: stride_q <= pwdata;
				REG_EXPECT: expect_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_ARENA0: prdata = arena0_q;
			REG_ARENA1: prdata = arena1_q;
			REG_STRIDE: prdata = stride_q;
			REG_EXPECT: prdata = expect_q;
			default: prdata = '0;
		endcase
	end

	lfsp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts),
		.cmd(cmd), .busy(busy), .done(done_i)
	);

	lfsp_datapath #(.CHANNELS(CHANNELS), .SLOTS(SLOTS), .WORKERS(WORKERS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd),
		.arena0_base(arena0_q), .arena1_base(arena1_q),
		.member_stride(stride_q), .expected_bytes(expect_q),
		.sts(sts), .rsp(rsp_i)
	);

	// Output register: the updated record is sampled the cycle after commit and
	// the beat is shown the cycle after that.
	logic done_q;
	rsp_t rsp_q;
	logic done_d1_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_d1_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_d1_q <= done_i;
			done_q <= done_d1_q;
		end
	end
	always_ff @(posedge clk) begin
		if (done_d1_q) rsp_q <= rsp_i;
	end
	assign done = done_q;
	assign rsp = rsp_q;

	`LFSP_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`LFSP_ASSERT_IMP(a_done_one, clk, arst_n, done_q, !done_d1_q)
	`LFSP_ASSERT_IMP(a_ok_fields, clk, arst_n, done_q && rsp_q.status == ST_OK,
		rsp_q.slot_state != PH_FREE || rsp_q.holder == 4'(WORKERS))
endmodule

FILE: rtl/lfsp_ctrl.sv
module lfsp_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  lfsp_pkg::sts_t sts,
	output lfsp_pkg::cmd_t cmd,
	output logic busy,
	output logic done
);
	import lfsp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				cmd.capture = start;
				if (start) state_d = S_READ;
			end
			S_READ: state_d = S_DECIDE;
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = sts.need_old ? S_OLD : S_WRITE;
			end
			S_OLD: begin
				cmd.check_old = 1'b1;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.commit = 1'b1;
				done = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

FILE: rtl/lfsp_datapath.sv
module lfsp_datapath #(
	parameter int CHANNELS = 16,
	parameter int SLOTS = 32,
	parameter int WORKERS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  lfsp_pkg::req_t req,
	input  lfsp_pkg::cmd_t cmd,
	input  logic [31:0] arena0_base,
	input  logic [31:0] arena1_base,
	input  logic [31:0] member_stride,
	input  logic [31:0] expected_bytes,
	output lfsp_pkg::sts_t sts,
	output lfsp_pkg::rsp_t rsp
);
	import lfsp_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Per-slot control in flip-flops; bulky payload also per slot, read at one index.
	logic [2:0]  phase_q [SLOTS];
	logic [31:0] gen_q   [SLOTS];
	logic [3:0]  owner_q [SLOTS];
	logic [4:0]  strm_q  [SLOTS];
	logic [63:0] frame_q [SLOTS];
	logic [63:0] time_q  [SLOTS];
	logic [31:0] fmt_q   [SLOTS];
	logic [31:0] bytes_q [SLOTS];
	logic [31:0] err_q   [SLOTS];
	logic [IW-1:0] latest_q [CHANNELS];
	logic [CHANNELS-1:0] lvalid_q;

	req_t req_q;
	logic [IW-1:0] idx_q, old_q;
	logic [1:0] stat_q;
	logic wr_q, touch_q, free_old_q, clr_lv_q, set_lv_q, none_q;
	logic [2:0] newph_q;
	logic [3:0] own_q;
	logic [CW-1:0] ch_q;
	logic have_free_q;
	logic [IW-1:0] free_idx_q;

	// Lowest free slot, registered at capture.
	logic have_free;
	logic [IW-1:0] free_idx;
	always_comb begin
		have_free = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (phase_q[i] == PH_FREE) begin
				have_free = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	logic [CW-1:0] rstrm, sstrm;
	assign rstrm = req_q.stream[CW-1:0];
	logic stream_ok, worker_ok, hidx_ok, handle_ok;
	logic [IW-1:0] hidx;
	assign stream_ok = 32'(req_q.stream) < CHANNELS;
	assign worker_ok = 32'(req_q.worker) < WORKERS;
	assign hidx_ok = 32'(req_q.handle_index) < SLOTS;
	assign hidx = req_q.handle_index[IW-1:0];
	assign handle_ok = hidx_ok && gen_q[hidx] == req_q.handle_generation;
	assign sstrm = strm_q[hidx][CW-1:0];

	logic [IW-1:0] lat_r, lat_s;
	assign lat_r = latest_q[rstrm];
	assign lat_s = latest_q[sstrm];

	// Decide step: for finish_write without fault, need the old slot's frame.
	logic fault;
	assign fault = req_q.write_fault != 0 || req_q.written_bytes != expected_bytes;
	assign sts.need_old = req_q.action == ACT_FINISH && handle_ok &&
		phase_q[hidx] == PH_WRITING && !fault && lvalid_q[sstrm];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
			have_free_q <= have_free;
			free_idx_q <= free_idx;
		end
		if (cmd.decide) begin
			wr_q <= 1'b0; touch_q <= 1'b0; free_old_q <= 1'b0;
			clr_lv_q <= 1'b0; set_lv_q <= 1'b0; none_q <= 1'b1;
			stat_q <= ST_BAD; idx_q <= hidx; newph_q <= PH_FREE;
			own_q <= 4'(WORKERS); ch_q <= rstrm; old_q <= lat_r;
			case (req_q.action)
				ACT_BEGIN: begin
					if (!stream_ok) stat_q <= ST_BAD;
					else if (have_free_q) begin
						stat_q <= ST_OK; none_q <= 1'b0; wr_q <= 1'b1;
						idx_q <= free_idx_q; newph_q <= PH_WRITING;
					end else if (!lvalid_q[rstrm] ||
						frame_q[lat_r] >= req_q.frame_number) begin
						stat_q <= ST_NONE;
					end else begin
						stat_q <= ST_OK; none_q <= 1'b0; wr_q <= 1'b1;
						idx_q <= lat_r; newph_q <= PH_WRITING; clr_lv_q <= 1'b1;
					end
				end
				ACT_FINISH: begin
					if (handle_ok && phase_q[hidx] == PH_WRITING) begin
						none_q <= 1'b0; touch_q <= 1'b1; ch_q <= sstrm;
						old_q <= lat_s;
						if (fault) begin
							stat_q <= ST_BAD; newph_q <= PH_ERROR;
						end else begin
							stat_q <= ST_OK; newph_q <= PH_READY; set_lv_q <= 1'b1;
						end
					end
				end
				ACT_ACQUIRE: begin
					if (!stream_ok || !worker_ok) stat_q <= ST_BAD;
					else if (!lvalid_q[rstrm]) stat_q <= ST_NONE;
					else if (phase_q[lat_r] == PH_READY) begin
						stat_q <= ST_OK; none_q <= 1'b0; idx_q <= lat_r;
						touch_q <= 1'b1; newph_q <= PH_RUNNING; clr_lv_q <= 1'b1;
						own_q <= {1'b0, req_q.worker};
					end
				end
				ACT_RELEASE: begin
					if (handle_ok && (phase_q[hidx] == PH_RUNNING ||
						phase_q[hidx] == PH_ERROR)) begin
						stat_q <= ST_OK; none_q <= 1'b0; touch_q <= 1'b1;
						newph_q <= PH_FREE;
					end
				end
				ACT_GET: begin
					if (handle_ok) begin
						stat_q <= ST_OK; none_q <= 1'b0;
						newph_q <= phase_q[hidx];
					end
				end
				default: stat_q <= ST_BAD;
			endcase
		end
		if (cmd.check_old) begin
			if (frame_q[old_q] >= frame_q[idx_q]) begin
				stat_q <= ST_NONE; newph_q <= PH_FREE; set_lv_q <= 1'b0;
			end else begin
				free_old_q <= 1'b1;
			end
		end
	end

	// State update, at commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				phase_q[i] <= PH_FREE;
				gen_q[i] <= '0;
				owner_q[i] <= 4'(WORKERS);
				strm_q[i] <= '0;
				frame_q[i] <= '0;
				time_q[i] <= '0;
				fmt_q[i] <= '0;
				bytes_q[i] <= '0;
				err_q[i] <= '0;
			end
			lvalid_q <= '0;
			for (int c = 0; c < CHANNELS; c++) latest_q[c] <= '0;
		end else if (cmd.commit) begin
			if (free_old_q) phase_q[old_q] <= PH_FREE;
			if (clr_lv_q) lvalid_q[ch_q] <= 1'b0;
			if (set_lv_q) begin
				lvalid_q[ch_q] <= 1'b1;
				latest_q[ch_q] <= idx_q;
			end
			if (wr_q) begin
				phase_q[idx_q] <= PH_WRITING;
				gen_q[idx_q] <= gen_q[idx_q] + 32'd1;
				strm_q[idx_q] <= req_q.stream;
				frame_q[idx_q] <= req_q.frame_number;
				time_q[idx_q] <= req_q.capture_time;
				fmt_q[idx_q] <= req_q.format_version;
				bytes_q[idx_q] <= '0;
				err_q[idx_q] <= '0;
				owner_q[idx_q] <= 4'(WORKERS);
			end
			if (touch_q) begin
				phase_q[idx_q] <= newph_q;
				owner_q[idx_q] <= own_q;
				if (req_q.action == ACT_FINISH) begin
					bytes_q[idx_q] <= req_q.written_bytes;
					if (newph_q == PH_ERROR)
						err_q[idx_q] <= (req_q.write_fault != 0) ? req_q.write_fault : 32'd1;
				end
			end
		end
	end

	// Result from the updated record; slots below CHANNELS lie in the first arena.
	logic [31:0] member, base;
	always_comb begin
		base = arena1_base;
		member = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (idx_q == IW'(i)) begin
				base = (i < CHANNELS) ? arena0_base : arena1_base;
				member = 32'(i % CHANNELS);
			end
		end
	end

	always_comb begin
		rsp = '0;
		rsp.status = stat_q;
		if (!none_q) begin
			rsp.slot_index = 6'(idx_q);
			rsp.slot_generation = gen_q[idx_q];
			rsp.slot_state = phase_q[idx_q];
			rsp.buf_addr = base + member * member_stride;
			rsp.holder = owner_q[idx_q];
			rsp.slot_frame = frame_q[idx_q];
			rsp.slot_timestamp = time_q[idx_q];
			rsp.slot_version = fmt_q[idx_q];
			rsp.slot_byte_count = bytes_q[idx_q];
			rsp.slot_error = err_q[idx_q];
			rsp.slot_stream = strm_q[idx_q][3:0];
		end
	end
endmodule

FILE: tb/sv/tb_latest_frame_slot_pool.sv
`timescale 1ns / 1ps
module tb_latest_frame_slot_pool;
	import lfsp_pkg::*;

	localparam int CHANNELS = 16;
	localparam int SLOTS = 32;
	localparam int WORKERS = 4;
	localparam int STALL_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	latest_frame_slot_pool #(
		.CHANNELS(CHANNELS),
		.SLOTS(SLOTS),
		.WORKERS(WORKERS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow copy of the pool used to predict every response.
	logic [2:0]  pool_phase [SLOTS];
	logic [31:0] pool_gen [SLOTS];
	logic [3:0]  pool_owner [SLOTS];
	logic [3:0]  pool_stream [SLOTS];
	logic [63:0] pool_frame [SLOTS];
	logic [63:0] pool_time [SLOTS];
	logic [31:0] pool_format [SLOTS];
	logic [31:0] pool_bytes [SLOTS];
	logic [31:0] pool_err [SLOTS];
	logic [4:0]  newest_slot [CHANNELS];
	bit          newest_valid [CHANNELS];
	logic [31:0] arena0_reg, arena1_reg, stride_reg, expect_reg;
	logic [63:0] next_frame [CHANNELS];

	rsp_t pending_rsp [$];
	rsp_t last_rsp;
	int errors;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] slot_addr(int i);
		logic [31:0] base;
		base = (i / CHANNELS == 0) ? arena0_reg : arena1_reg;
		return base + 32'(i % CHANNELS) * stride_reg;
	endfunction

	function automatic rsp_t slot_view(logic [1:0] st, int i);
		rsp_t o;
		o.status = st;
		o.slot_index = 6'(i);
		o.slot_generation = pool_gen[i];
		o.slot_state = pool_phase[i];
		o.buf_addr = slot_addr(i);
		o.holder = pool_owner[i];
		o.slot_frame = pool_frame[i];
		o.slot_timestamp = pool_time[i];
		o.slot_version = pool_format[i];
		o.slot_byte_count = pool_bytes[i];
		o.slot_error = pool_err[i];
		o.slot_stream = pool_stream[i];
		return o;
	endfunction

	function automatic rsp_t no_slot(logic [1:0] st);
		rsp_t o;
		o = '0;
		o.status = st;
		return o;
	endfunction

	// Applies one request to the shadow pool and returns its response.
	function automatic rsp_t pool_apply(req_t r);
		int i, s, old;
		bit handle_ok;
		handle_ok = r.handle_index < SLOTS && pool_gen[r.handle_index] == r.handle_generation;
		i = r.handle_index;
		case (r.action)
			ACT_BEGIN: begin
				if (r.stream >= CHANNELS) return no_slot(ST_BAD);
				s = r.stream;
				for (i = 0; i < SLOTS; i++)
					if (pool_phase[i] == PH_FREE) break;
				if (i == SLOTS) begin
					if (!newest_valid[s]) return no_slot(ST_NONE);
					i = newest_slot[s];
					if (pool_frame[i] >= r.frame_number) return no_slot(ST_NONE);
					newest_valid[s] = 0;
				end
				pool_gen[i] = pool_gen[i] + 1;
				pool_stream[i] = 4'(s);
				pool_frame[i] = r.frame_number;
				pool_time[i] = r.capture_time;
				pool_format[i] = r.format_version;
				pool_bytes[i] = '0;
				pool_err[i] = '0;
				pool_owner[i] = 4'(WORKERS);
				pool_phase[i] = PH_WRITING;
				return slot_view(ST_OK, i);
			end
			ACT_FINISH: begin
				if (!handle_ok || pool_phase[i] != PH_WRITING) return no_slot(ST_BAD);
				pool_bytes[i] = r.written_bytes;
				if (r.write_fault != 0 || r.written_bytes != expect_reg) begin
					pool_err[i] = (r.write_fault != 0) ? r.write_fault : 32'd1;
					pool_phase[i] = PH_ERROR;
					return slot_view(ST_BAD, i);
				end
				s = pool_stream[i];
				if (newest_valid[s]) begin
					old = newest_slot[s];
					if (pool_frame[old] >= pool_frame[i]) begin
						pool_phase[i] = PH_FREE;
						return slot_view(ST_NONE, i);
					end
					pool_phase[old] = PH_FREE;
				end
				pool_phase[i] = PH_READY;
				newest_slot[s] = 5'(i);
				newest_valid[s] = 1;
				return slot_view(ST_OK, i);
			end
			ACT_ACQUIRE: begin
				if (r.stream >= CHANNELS || r.worker >= WORKERS) return no_slot(ST_BAD);
				s = r.stream;
				if (!newest_valid[s]) return no_slot(ST_NONE);
				i = newest_slot[s];
				if (pool_phase[i] != PH_READY) return no_slot(ST_BAD);
				pool_phase[i] = PH_RUNNING;
				pool_owner[i] = 4'(r.worker);
				newest_valid[s] = 0;
				return slot_view(ST_OK, i);
			end
			ACT_RELEASE: begin
				if (!handle_ok || (pool_phase[i] != PH_RUNNING && pool_phase[i] != PH_ERROR))
					return no_slot(ST_BAD);
				pool_phase[i] = PH_FREE;
				pool_owner[i] = 4'(WORKERS);
				return slot_view(ST_OK, i);
			end
			ACT_GET: begin
				if (!handle_ok) return no_slot(ST_BAD);
				return slot_view(ST_OK, i);
			end
			default: return no_slot(ST_BAD);
		endcase
	endfunction

	// busy only moves at the rising edge, so it is stable at the falling edge.
	task automatic send_item(req_t r);
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		while (busy) @(negedge clk);
		@(posedge clk);
		last_rsp = pool_apply(r);
		pending_rsp.push_back(last_rsp);
	endtask

	task automatic pause_sender(int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ARENA0: arena0_reg = value;
			REG_ARENA1: arena1_reg = value;
			REG_STRIDE: stride_reg = value;
			default: expect_reg = value;
		endcase
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== value) begin
			$error("prdata: expected %h, actual %h", value, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_regs(logic [31:0] a0, logic [31:0] a1, logic [31:0] st,
			logic [31:0] ex);
		drain_results();
		write_reg(REG_ARENA0, a0);
		write_reg(REG_ARENA1, a1);
		write_reg(REG_STRIDE, st);
		write_reg(REG_EXPECT, ex);
	endtask

	function automatic req_t make_req(logic [2:0] act, logic [4:0] s);
		req_t r;
		r = '0;
		r.action = act;
		r.stream = s;
		return r;
	endfunction

	function automatic req_t handle_req(logic [2:0] act, rsp_t h);
		req_t r;
		r = make_req(act, 5'd0);
		r.handle_index = h.slot_index;
		r.handle_generation = h.slot_generation;
		r.written_bytes = expect_reg;
		return r;
	endfunction

	function automatic int find_slot(logic [2:0] ph, logic [2:0] alt);
		int first, i;
		first = $urandom_range(SLOTS - 1);
		for (int k = 0; k < SLOTS; k++) begin
			i = (first + k) % SLOTS;
			if (pool_phase[i] == ph || pool_phase[i] == alt) return i;
		end
		return first;
	endfunction

	function automatic req_t random_req();
		req_t r;
		int k, s, i;
		r = '0;
		r.capture_time = {$urandom, $urandom};
		r.format_version = $urandom;
		s = ($urandom_range(19) == 0) ? $urandom_range(31) : $urandom_range(CHANNELS - 1);
		r.stream = 5'(s);
		r.worker = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
		i = $urandom_range(SLOTS - 1);
		k = $urandom_range(99);
		if (k < 30) begin
			r.action = ACT_BEGIN;
			k = $urandom_range(9);
			if (k == 0)
				r.frame_number = {$urandom, $urandom};
			else if (k == 1)
				r.frame_number = next_frame[s % CHANNELS] - $urandom_range(3);
			else begin
				next_frame[s % CHANNELS] += $urandom_range(1, 3);
				r.frame_number = next_frame[s % CHANNELS];
			end
		end else if (k < 55) begin
			r.action = ACT_FINISH;
			i = find_slot(PH_WRITING, PH_WRITING);
		end else if (k < 70) begin
			r.action = ACT_ACQUIRE;
		end else if (k < 85) begin
			r.action = ACT_RELEASE;
			i = find_slot(PH_RUNNING, PH_ERROR);
		end else if (k < 95) begin
			r.action = ACT_GET;
		end else begin
			r.action = 3'($urandom_range(7));
			r.frame_number = {$urandom, $urandom};
		end
		r.written_bytes = ($urandom_range(9) == 0) ? $urandom : expect_reg;
		r.write_fault = ($urandom_range(11) == 0) ? $urandom : 32'd0;
		r.handle_index = 6'(i);
		r.handle_generation = pool_gen[i];
		if ($urandom_range(14) == 0) r.handle_index = 6'($urandom_range(63));
		if ($urandom_range(14) == 0) r.handle_generation = $urandom;
		return r;
	endfunction

	task automatic test_directed();
		req_t r;
		rsp_t h0, h1, h2, h4;
		r = make_req(ACT_BEGIN, 5'd0);
		r.frame_number = 64'd5;
		r.capture_time = '1;
		r.format_version = '1;
		send_item(r);
		h0 = last_rsp;
		r = make_req(ACT_BEGIN, 5'd15);
		r.frame_number = '1;
		send_item(r);
		h1 = last_rsp;
		send_item(make_req(ACT_BEGIN, 5'd16));
		send_item(make_req(ACT_BEGIN, 5'd31));
		send_item(handle_req(ACT_FINISH, h0));
		r = make_req(ACT_ACQUIRE, 5'd0);
		r.worker = 3'd3;
		send_item(r);
		send_item(r);
		r.worker = 3'd7;
		send_item(r);
		send_item(make_req(ACT_ACQUIRE, 5'd31));
		r = handle_req(ACT_RELEASE, h0);
		r.handle_generation = ~r.handle_generation;
		send_item(r);
		send_item(handle_req(ACT_RELEASE, h0));
		r = handle_req(ACT_FINISH, h1);
		r.write_fault = '1;
		send_item(r);
		send_item(handle_req(ACT_RELEASE, h1));
		r = make_req(ACT_BEGIN, 5'd2);
		r.frame_number = 64'd10;
		send_item(r);
		h2 = last_rsp;
		send_item(handle_req(ACT_FINISH, h2));
		r.frame_number = 64'd9;
		send_item(r);
		// An older frame finishing after a newer one is dropped.
		send_item(handle_req(ACT_FINISH, last_rsp));
		r.frame_number = 64'd20;
		send_item(r);
		h4 = last_rsp;
		r = handle_req(ACT_FINISH, h4);
		r.written_bytes = expect_reg - 1;
		send_item(r);
		r = make_req(ACT_GET, 5'd0);
		r.handle_index = 6'd63;
		send_item(r);
		send_item(handle_req(ACT_GET, h2));
		send_item(make_req(3'd5, 5'd0));
		send_item(make_req(3'd7, 5'd0));
		send_item(handle_req(ACT_FINISH, h2));
		send_item(handle_req(ACT_RELEASE, h4));
	endtask

	// Fills the pool so that begin_write has to reclaim a stream's ready slot.
	task automatic test_pool_full();
		req_t r;
		for (int s = 0; s < 4; s++) begin
			next_frame[s] += 5;
			r = make_req(ACT_BEGIN, 5'(s));
			r.frame_number = next_frame[s];
			send_item(r);
			if (last_rsp.status == ST_OK) send_item(handle_req(ACT_FINISH, last_rsp));
		end
		repeat (SLOTS + 2) begin
			r = make_req(ACT_BEGIN, 5'd8);
			r.frame_number = {$urandom, $urandom};
			send_item(r);
		end
		for (int s = 0; s < 5; s++) begin
			r = make_req(ACT_BEGIN, 5'(s));
			r.frame_number = (s == 1) ? 64'd0 : next_frame[s % CHANNELS] + 1;
			send_item(r);
			r.frame_number = next_frame[s % CHANNELS] + 2;
			send_item(r);
		end
	endtask

	task automatic test_random(int n);
		int burst;
		burst = 0;
		for (int k = 0; k < n; k++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				if ($urandom_range(2) != 0) pause_sender($urandom_range(1, 12));
			end
			burst--;
			send_item(random_req());
		end
	endtask

	// Response checker.
	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, actual %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("response beat with no request outstanding");
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				check_field("status", e.status, rsp.status);
				check_field("slot_index", e.slot_index, rsp.slot_index);
				check_field("slot_generation", e.slot_generation, rsp.slot_generation);
				check_field("slot_state", e.slot_state, rsp.slot_state);
				check_field("buf_addr", e.buf_addr, rsp.buf_addr);
				check_field("holder", e.holder, rsp.holder);
				check_field("slot_frame", e.slot_frame, rsp.slot_frame);
				check_field("slot_timestamp", e.slot_timestamp, rsp.slot_timestamp);
				check_field("slot_version", e.slot_version, rsp.slot_version);
				check_field("slot_byte_count", e.slot_byte_count, rsp.slot_byte_count);
				check_field("slot_error", e.slot_error, rsp.slot_error);
				check_field("slot_stream", e.slot_stream, rsp.slot_stream);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		idle_cycles = 0;
		arena0_reg = '0;
		arena1_reg = '0;
		stride_reg = '0;
		expect_reg = '0;
		for (int i = 0; i < SLOTS; i++) begin
			pool_phase[i] = PH_FREE;
			pool_gen[i] = '0;
			pool_owner[i] = 4'(WORKERS);
			pool_stream[i] = '0;
			pool_frame[i] = '0;
			pool_time[i] = '0;
			pool_format[i] = '0;
			pool_bytes[i] = '0;
			pool_err[i] = '0;
		end
		for (int s = 0; s < CHANNELS; s++) begin
			newest_slot[s] = '0;
			newest_valid[s] = 0;
			next_frame[s] = 64'd100;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_random(60);
		set_regs(32'h1000_0000, 32'h8000_0000, 32'h0010_0000, 32'd256);
		test_directed();
		test_pool_full();
		test_random(300);
		set_regs('1, '0, '1, '0);
		test_random(250);
		set_regs('0, '1, 32'd1, '1);
		test_pool_full();
		test_random(250);
		set_regs($urandom, $urandom, $urandom, $urandom);
		test_random(200);

		drain_results();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
